[rtl/sppm_pkg.sv]
// ----------------------------------------------------------------------------
// sppm_pkg
// shared types and constants for the pixel statistics update pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package sppm_pkg;

  localparam int CNT_W    = 32;  // photon count, Q16.16
  localparam int CNTX_W   = 33;  // unclamped count N' and denominator
  localparam int NEW_W    = 16;  // new photons M
  localparam int RAD_W    = 32;  // radius, Q16.16
  localparam int FLUX_W   = 40;  // flux, Q24.16
  localparam int WGT_W    = 24;  // weight, Q8.16
  localparam int ALPHA_W  = 16;  // update fraction, Q0.16
  localparam int ACC_W    = 49;  // tau + w*phi, exact
  localparam int PHI_LO_W = 20;  // low slice of phi for the split product
  localparam int PP_W     = WGT_W + PHI_LO_W;
  localparam int WP_W     = 64;  // full w*phi product
  localparam int ACC_LO_W = 25;  // low slice of the flux sum for the split product
  localparam int ACC_HI_W = ACC_W - ACC_LO_W;
  localparam int NCH      = 3;   // colour channels

  // side data that travels with a transaction down the cell chain
  typedef struct packed {
    logic                              m_zero;
    logic [CNTX_W-1:0]                 cnt;
    logic [RAD_W-1:0]                  rad;
    logic [NCH-1:0][ACC_W-1:0]         acc;
  } ctx_t;

endpackage

`default_nettype wire

[rtl/sppm_div_cell.sv]
// ----------------------------------------------------------------------------
// sppm_div_cell
// one restoring division cell: produces one quotient bit per transaction
// ----------------------------------------------------------------------------
`default_nettype none

module sppm_div_cell #(
  parameter int RB = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        up_valid,
  output logic                             up_ready,
  input  wire sppm_pkg::ctx_t              up_ctx,
  input  wire logic [sppm_pkg::CNTX_W-1:0] up_rem,
  input  wire logic [sppm_pkg::CNTX_W-1:0] up_den,
  input  wire logic [RB-1:0]               up_q,
  output logic                             dn_valid,
  input  wire logic                        dn_ready,
  output sppm_pkg::ctx_t                   dn_ctx,
  output logic [sppm_pkg::CNTX_W-1:0]      dn_rem,
  output logic [sppm_pkg::CNTX_W-1:0]      dn_den,
  output logic [RB-1:0]                    dn_q
);

  logic                          valid_r;
  sppm_pkg::ctx_t                ctx_r;
  logic [sppm_pkg::CNTX_W-1:0]   rem_r, rem_nxt;
  logic [sppm_pkg::CNTX_W-1:0]   den_r;
  logic [RB-1:0]                 q_r, q_nxt;
  logic [sppm_pkg::CNTX_W:0]     rem_sh, rem_sub;
  logic                          ge;

  always_comb begin
    rem_sh  = {up_rem, 1'b0};
    rem_sub = rem_sh - {1'b0, up_den};
    ge      = (rem_sh >= {1'b0, up_den});
    rem_nxt = ge ? rem_sub[sppm_pkg::CNTX_W-1:0] : rem_sh[sppm_pkg::CNTX_W-1:0];
    q_nxt   = {up_q[RB-2:0], ge};
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      ctx_r <= up_ctx;
      rem_r <= rem_nxt;
      den_r <= up_den;
      q_r   <= q_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_ctx   = ctx_r;
  assign dn_rem   = rem_r;
  assign dn_den   = den_r;
  assign dn_q     = q_r;

endmodule

`default_nettype wire

[rtl/sppm_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// sppm_sqrt_cell
// one digit-by-digit square root cell: produces one root bit per transaction
// ----------------------------------------------------------------------------
`default_nettype none

module sppm_sqrt_cell #(
  parameter int RB = 24
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           up_valid,
  output logic                up_ready,
  input  wire sppm_pkg::ctx_t up_ctx,
  input  wire logic [2*RB-1:0] up_v,
  input  wire logic [RB+1:0]  up_rem,
  input  wire logic [RB-1:0]  up_root,
  input  wire logic [RB-1:0]  up_q,
  output logic                dn_valid,
  input  wire logic           dn_ready,
  output sppm_pkg::ctx_t      dn_ctx,
  output logic [2*RB-1:0]     dn_v,
  output logic [RB+1:0]       dn_rem,
  output logic [RB-1:0]       dn_root,
  output logic [RB-1:0]       dn_q
);

  logic              valid_r;
  sppm_pkg::ctx_t    ctx_r;
  logic [2*RB-1:0]   v_r, v_nxt;
  logic [RB+1:0]     rem_r, rem_nxt;
  logic [RB-1:0]     root_r, root_nxt;
  logic [RB-1:0]     q_r;
  logic [RB+3:0]     rem4, trial, diff;
  logic              ge;

  always_comb begin
    rem4     = {up_rem, up_v[2*RB-1 -: 2]};
    trial    = {2'b00, up_root, 2'b01};
    diff     = rem4 - trial;
    ge       = (rem4 >= trial);
    rem_nxt  = ge ? diff[RB+1:0] : rem4[RB+1:0];
    root_nxt = {up_root[RB-2:0], ge};
    v_nxt    = {up_v[2*RB-3:0], 2'b00};
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      ctx_r  <= up_ctx;
      v_r    <= v_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      q_r    <= up_q;
    end
  end

  assign dn_valid = valid_r;
  assign dn_ctx   = ctx_r;
  assign dn_v     = v_r;
  assign dn_rem   = rem_r;
  assign dn_root  = root_r;
  assign dn_q     = q_r;

endmodule

`default_nettype wire

[rtl/sppm_pixel_statistics_update_unit.sv]
// pipeline: stage 0, stage 1, the division chain, the square root chain, the multiply
//   stage and the output register; one transaction per cycle while out_stall does not
//   hold the output; each division cell gives one quotient bit, each root cell one root bit
// reset: synchronous active-low rst_n empties every stage and loads
//   update_fraction with 45875 (alpha of about 0.7)
// ----------------------------------------------------------------------------
// sppm_pixel_statistics_update_unit
// progressive photon mapping per-pixel count, radius and flux update
// ----------------------------------------------------------------------------
`default_nettype none

module sppm_pixel_statistics_update_unit #(
  parameter int RATIO_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sppm_pkg::ALPHA_W-1:0]  cfg_update_fraction,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [sppm_pkg::CNT_W-1:0]    in_photon_count,
  input  wire logic [sppm_pkg::NEW_W-1:0]    in_new_photons,
  input  wire logic [sppm_pkg::RAD_W-1:0]    in_radius,
  input  wire logic [sppm_pkg::FLUX_W-1:0]   in_flux_red,
  input  wire logic [sppm_pkg::FLUX_W-1:0]   in_flux_green,
  input  wire logic [sppm_pkg::FLUX_W-1:0]   in_flux_blue,
  input  wire logic [sppm_pkg::FLUX_W-1:0]   in_gathered_red,
  input  wire logic [sppm_pkg::FLUX_W-1:0]   in_gathered_green,
  input  wire logic [sppm_pkg::FLUX_W-1:0]   in_gathered_blue,
  input  wire logic [sppm_pkg::WGT_W-1:0]    in_weight_red,
  input  wire logic [sppm_pkg::WGT_W-1:0]    in_weight_green,
  input  wire logic [sppm_pkg::WGT_W-1:0]    in_weight_blue,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [sppm_pkg::CNT_W-1:0]         out_next_photon_count,
  output logic [sppm_pkg::RAD_W-1:0]         out_next_radius,
  output logic [sppm_pkg::FLUX_W-1:0]        out_next_flux_red,
  output logic [sppm_pkg::FLUX_W-1:0]        out_next_flux_green,
  output logic [sppm_pkg::FLUX_W-1:0]        out_next_flux_blue,
  output logic                               out_saturated
);

  localparam int RB     = RATIO_BITS;
  localparam int CNTX_W = sppm_pkg::CNTX_W;
  localparam int FLUX_W = sppm_pkg::FLUX_W;
  localparam int ACC_W  = sppm_pkg::ACC_W;
  localparam int PP_W   = sppm_pkg::PP_W;
  localparam int NCH    = sppm_pkg::NCH;
  localparam int FULL_W = ACC_W + RB;

  // ---------------------------------------------------------------------------
  // configuration register; not enforced here: to be written only while the pipeline is empty
  // ---------------------------------------------------------------------------
  logic [sppm_pkg::ALPHA_W-1:0] alpha_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= sppm_pkg::ALPHA_W'(45875);
    end else if (cfg_valid && cfg_ready) begin
      alpha_r <= cfg_update_fraction;
    end
  end

  // ready ripples backwards: a stage takes new data when it is empty or
  // its own content moves on in the same cycle
  logic out_rdy, m1_rdy, s1_rdy, s0_rdy;
  logic out_valid_r, m1_v_r, s1_v_r, s0_v_r;

  // ---------------------------------------------------------------------------
  // stage 0: N' = N + alpha*M, denominator N + M<<16, split w*phi products
  // ---------------------------------------------------------------------------
  logic [sppm_pkg::FLUX_W-1:0] tau_in [NCH];
  logic [sppm_pkg::FLUX_W-1:0] phi_in [NCH];
  logic [sppm_pkg::WGT_W-1:0]  w_in   [NCH];

  assign tau_in[0] = in_flux_red;
  assign tau_in[1] = in_flux_green;
  assign tau_in[2] = in_flux_blue;
  assign phi_in[0] = in_gathered_red;
  assign phi_in[1] = in_gathered_green;
  assign phi_in[2] = in_gathered_blue;
  assign w_in[0]   = in_weight_red;
  assign w_in[1]   = in_weight_green;
  assign w_in[2]   = in_weight_blue;

  logic                         s0_mz_r;
  logic [sppm_pkg::CNT_W-1:0]   s0_n_r;
  logic [CNTX_W-1:0]            s0_nnew_r, s0_den_r;
  logic [sppm_pkg::RAD_W-1:0]   s0_rad_r;
  logic [FLUX_W-1:0]            s0_tau_r [NCH];
  logic [PP_W-1:0]              s0_pl_r  [NCH];
  logic [PP_W-1:0]              s0_ph_r  [NCH];
  logic [2*sppm_pkg::NEW_W-1:0] am_prod;
  logic                         in_take;

  assign am_prod  = alpha_r * in_new_photons;
  assign in_take  = in_valid && !in_stall;
  assign in_stall = !s0_rdy;
  assign s0_rdy   = !s0_v_r || s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (s0_rdy) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_mz_r   <= (in_new_photons == '0);
      s0_n_r    <= in_photon_count;
      s0_nnew_r <= {1'b0, in_photon_count} + CNTX_W'(am_prod);
      s0_den_r  <= {1'b0, in_photon_count} + {1'b0, in_new_photons, 16'h0000};
      s0_rad_r  <= in_radius;
      for (int c = 0; c < NCH; c++) begin
        s0_tau_r[c] <= tau_in[c];
        s0_pl_r[c]  <= w_in[c] * phi_in[c][sppm_pkg::PHI_LO_W-1:0];
        s0_ph_r[c]  <= w_in[c] * phi_in[c][FLUX_W-1:sppm_pkg::PHI_LO_W];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: tau + (w*phi >> 16), build the context that rides the chain
  // ---------------------------------------------------------------------------
  sppm_pkg::ctx_t    s1_ctx_r, s1_ctx_nxt;
  logic [CNTX_W-1:0] s1_rem_r, s1_den_r;
  logic [sppm_pkg::WP_W-1:0] wp [NCH];

  always_comb begin
    s1_ctx_nxt.m_zero = s0_mz_r;
    s1_ctx_nxt.cnt    = s0_mz_r ? {1'b0, s0_n_r} : s0_nnew_r;
    s1_ctx_nxt.rad    = s0_rad_r;
    for (int c = 0; c < NCH; c++) begin
      wp[c] = (sppm_pkg::WP_W'(s0_ph_r[c]) << sppm_pkg::PHI_LO_W)
            + sppm_pkg::WP_W'(s0_pl_r[c]);
      // no new photons: the flux passes through untouched
      s1_ctx_nxt.acc[c] = s0_mz_r ? ACC_W'(s0_tau_r[c])
                                  : ACC_W'(s0_tau_r[c]) + ACC_W'(wp[c] >> 16);
    end
  end

  logic div_up_ready;
  assign s1_rdy = !s1_v_r || div_up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && s0_v_r) begin
      s1_ctx_r <= s1_ctx_nxt;
      s1_rem_r <= s0_nnew_r;  // N' < N + M<<16 when M is nonzero, so the integer quotient is zero
      s1_den_r <= s0_den_r;
    end
  end

  // ---------------------------------------------------------------------------
  // division chain: q = floor(N' * 2^RB / den), one quotient bit per cell
  // ---------------------------------------------------------------------------
  logic              dv_v   [RB+1];
  logic              dv_rdy [RB+1];
  sppm_pkg::ctx_t    dv_ctx [RB+1];
  logic [CNTX_W-1:0] dv_rem [RB+1];
  logic [CNTX_W-1:0] dv_den [RB+1];
  logic [RB-1:0]     dv_q   [RB+1];

  assign dv_v[0]      = s1_v_r;
  assign dv_ctx[0]    = s1_ctx_r;
  assign dv_rem[0]    = s1_rem_r;
  assign dv_den[0]    = s1_den_r;
  assign dv_q[0]      = '0;
  assign div_up_ready = dv_rdy[0];

  for (genvar i = 0; i < RB; i++) begin : g_div
    sppm_div_cell #(.RB(RB)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv_v[i]),
      .up_ready (dv_rdy[i]),
      .up_ctx   (dv_ctx[i]),
      .up_rem   (dv_rem[i]),
      .up_den   (dv_den[i]),
      .up_q     (dv_q[i]),
      .dn_valid (dv_v[i+1]),
      .dn_ready (dv_rdy[i+1]),
      .dn_ctx   (dv_ctx[i+1]),
      .dn_rem   (dv_rem[i+1]),
      .dn_den   (dv_den[i+1]),
      .dn_q     (dv_q[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // square root chain: s = floor(sqrt(q << RB)), one root bit per cell
  // ---------------------------------------------------------------------------
  logic            sq_v    [RB+1];
  logic            sq_rdy  [RB+1];
  sppm_pkg::ctx_t  sq_ctx  [RB+1];
  logic [2*RB-1:0] sq_vv   [RB+1];
  logic [RB+1:0]   sq_rem  [RB+1];
  logic [RB-1:0]   sq_root [RB+1];
  logic [RB-1:0]   sq_q    [RB+1];

  assign sq_v[0]    = dv_v[RB];
  assign dv_rdy[RB] = sq_rdy[0];
  assign sq_ctx[0]  = dv_ctx[RB];
  assign sq_vv[0]   = {dv_q[RB], {RB{1'b0}}};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_q[0]    = dv_q[RB];

  for (genvar i = 0; i < RB; i++) begin : g_sqrt
    sppm_sqrt_cell #(.RB(RB)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (sq_v[i]),
      .up_ready (sq_rdy[i]),
      .up_ctx   (sq_ctx[i]),
      .up_v     (sq_vv[i]),
      .up_rem   (sq_rem[i]),
      .up_root  (sq_root[i]),
      .up_q     (sq_q[i]),
      .dn_valid (sq_v[i+1]),
      .dn_ready (sq_rdy[i+1]),
      .dn_ctx   (sq_ctx[i+1]),
      .dn_v     (sq_vv[i+1]),
      .dn_rem   (sq_rem[i+1]),
      .dn_root  (sq_root[i+1]),
      .dn_q     (sq_q[i+1])
    );
  end

  assign sq_rdy[RB] = m1_rdy;

  // ---------------------------------------------------------------------------
  // multiply stage: R*s and the flux sum times q, sum split in two slices
  // ---------------------------------------------------------------------------
  sppm_pkg::ctx_t                      m1_ctx_r;
  logic [sppm_pkg::RAD_W+RB-1:0]       m1_rad_r;
  logic [sppm_pkg::ACC_LO_W+RB-1:0]    m1_flo_r [NCH];
  logic [sppm_pkg::ACC_HI_W+RB-1:0]    m1_fhi_r [NCH];

  assign m1_rdy = !m1_v_r || out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (m1_rdy) begin
      m1_v_r <= sq_v[RB];
    end
  end

  always_ff @(posedge clk) begin
    if (m1_rdy && sq_v[RB]) begin
      m1_ctx_r <= sq_ctx[RB];
      m1_rad_r <= sq_ctx[RB].rad * sq_root[RB];
      for (int c = 0; c < NCH; c++) begin
        m1_flo_r[c] <= sq_ctx[RB].acc[c][sppm_pkg::ACC_LO_W-1:0] * sq_q[RB];
        m1_fhi_r[c] <= sq_ctx[RB].acc[c][ACC_W-1:sppm_pkg::ACC_LO_W] * sq_q[RB];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register: recombine, shift down by RB, clamp and flag
  // ---------------------------------------------------------------------------
  logic [FULL_W-1:0]          fl_full [NCH];
  logic [ACC_W-1:0]           fl_shr  [NCH];
  logic [FLUX_W-1:0]          fl_res  [NCH];
  logic [NCH-1:0]             fl_sat;
  logic                       cnt_sat;
  logic [sppm_pkg::CNT_W-1:0] cnt_res;
  logic [sppm_pkg::RAD_W-1:0] rad_res;
  logic                       sat_res;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      fl_full[c] = (FULL_W'(m1_fhi_r[c]) << sppm_pkg::ACC_LO_W) + FULL_W'(m1_flo_r[c]);
      fl_shr[c]  = fl_full[c][RB +: ACC_W];
      fl_sat[c]  = !m1_ctx_r.m_zero && (fl_shr[c][ACC_W-1:FLUX_W] != '0);
      if (m1_ctx_r.m_zero) begin
        fl_res[c] = m1_ctx_r.acc[c][FLUX_W-1:0];
      end else if (fl_sat[c]) begin
        fl_res[c] = '1;
      end else begin
        fl_res[c] = fl_shr[c][FLUX_W-1:0];
      end
    end
    // count clamps at all ones; the ratio above used the unclamped value
    cnt_sat = !m1_ctx_r.m_zero && m1_ctx_r.cnt[CNTX_W-1];
    cnt_res = cnt_sat ? '1 : m1_ctx_r.cnt[CNTX_W-2:0];
    rad_res = m1_ctx_r.m_zero ? m1_ctx_r.rad : m1_rad_r[RB +: sppm_pkg::RAD_W];
    sat_res = cnt_sat || (|fl_sat);
  end

  assign out_rdy = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && m1_v_r) begin
      out_next_photon_count <= cnt_res;
      out_next_radius       <= rad_res;
      out_next_flux_red     <= fl_res[0];
      out_next_flux_green   <= fl_res[1];
      out_next_flux_blue    <= fl_res[2];
      out_saturated         <= sat_res;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // an empty output register must never back-pressure the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled with an empty output register");

  // the flag is only raised when some result sits at its maximum
  a_sat_means_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_next_photon_count == '1 || out_next_flux_red == '1 ||
       out_next_flux_green == '1 || out_next_flux_blue == '1))
    else $error("saturated flag without a clamped result");

  // sqrt of a ratio below one can only shrink the radius
  a_radius_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    m1_v_r |-> (m1_rad_r[RB +: sppm_pkg::RAD_W] <= m1_ctx_r.rad))
    else $error("updated radius larger than current radius");

endmodule

`default_nettype wire
